// File: src/rlmb_pkg.sv
// ----------------------------------------------------------------------------
// rlmb_pkg
// Shared sizes and types for the recency list with move-to-newest.
// ----------------------------------------------------------------------------
package rlmb_pkg;

    localparam int LIST_DEPTH = 7;
    localparam int ID_W       = 22;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        ST_NEWEST = 2'd0,
        ST_HIT    = 2'd1,
        ST_MISS   = 2'd2
    } status_t;

    typedef struct packed {
        logic hit;
        idx_t idx;
    } match_t;

    typedef struct packed {
        status_t status;
        id_t     evicted_pid;
        id_t     newest_pid;
        id_t     newest_render_id;
    } result_t;

endpackage

// File: src/rlmb_match.sv
// ----------------------------------------------------------------------------
// rlmb_match
// Parallel compare of a pid against every slot, first match from the oldest.
// ----------------------------------------------------------------------------
module rlmb_match
    import rlmb_pkg::*;
(
    input  id_t    slot_pid [LIST_DEPTH],
    input  id_t    pid,
    output match_t match
);

    logic [LIST_DEPTH-1:0] eq;

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            eq[i] = (slot_pid[i] == pid);
        end
    end

    // Walk from the newest down so that the oldest match is the one left.
    always_comb
    begin
        match.hit = 1'b0;
        match.idx = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (eq[i])
            begin
                match.hit = 1'b1;
                match.idx = IDX_W'(i);
            end
        end
    end

endmodule

// File: src/rlmb_list.sv
// ----------------------------------------------------------------------------
// rlmb_list
// Slot storage and the reorder: move to newest or evict oldest.
// ----------------------------------------------------------------------------
module rlmb_list
    import rlmb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    upd_en,
    input  id_t     pid,
    input  id_t     render_id,
    output result_t result
);

    id_t    pid_reg  [LIST_DEPTH];
    id_t    rtid_reg [LIST_DEPTH];
    id_t    pid_next [LIST_DEPTH];
    id_t    rtid_next[LIST_DEPTH];
    match_t match;
    logic   miss;
    logic   shift;

    rlmb_match u_match
    (
        .slot_pid (pid_reg),
        .pid      (pid),
        .match    (match)
    );

    assign miss = !match.hit;

    // A miss behaves like a hit on the oldest slot whose entry is the new pair.
    always_comb
    begin
        shift = 1'b0;
        for (int i = 0; i < LIST_DEPTH - 1; i++)
        begin
            shift = miss || (IDX_W'(i) >= match.idx);
            if (shift)
            begin
                pid_next[i]  = pid_reg[i+1];
                rtid_next[i] = rtid_reg[i+1];
            end
            else
            begin
                pid_next[i]  = pid_reg[i];
                rtid_next[i] = rtid_reg[i];
            end
        end
        if (miss)
        begin
            pid_next[LIST_DEPTH-1]  = pid;
            rtid_next[LIST_DEPTH-1] = render_id;
        end
        else
        begin
            pid_next[LIST_DEPTH-1]  = pid_reg[match.idx];
            rtid_next[LIST_DEPTH-1] = rtid_reg[match.idx];
        end
    end

    always_comb
    begin
        if (miss)
        begin
            result.status      = ST_MISS;
            result.evicted_pid = pid_reg[0];
        end
        else if (match.idx == IDX_W'(LIST_DEPTH - 1))
        begin
            result.status      = ST_NEWEST;
            result.evicted_pid = '0;
        end
        else
        begin
            result.status      = ST_HIT;
            result.evicted_pid = '0;
        end
        result.newest_pid       = pid_next[LIST_DEPTH-1];
        result.newest_render_id = rtid_next[LIST_DEPTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                pid_reg[i]  <= '0;
                rtid_reg[i] <= '0;
            end
        end
        else if (upd_en)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                pid_reg[i]  <= pid_next[i];
                rtid_reg[i] <= rtid_next[i];
            end
        end
    end

endmodule

// File: src/recency_list_move_to_back_top.sv
// ----------------------------------------------------------------------------
// recency_list_move_to_back_top
// Recency list of pid/render id pairs, oldest first, with move-to-newest.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, pid, render_id             | into block
//  out     | out_valid, out_stall, status, evicted_pid,     | out of block
//          | newest_pid, newest_render_id                   |
//
// One transfer per cycle is sustained while out_stall stays low. A pid goes
// through an input register, then the compare and reorder of all slots into
// the result register. Reset clears every slot to pid 0 and render id 0 and
// empties both stages. When out_stall holds the result, the input register
// keeps its item and in_stall rises once that register is full.
// ----------------------------------------------------------------------------
module recency_list_move_to_back_top
    import rlmb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [ID_W-1:0] pid,
    input  logic [ID_W-1:0] render_id,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     status,
    output logic [ID_W-1:0] evicted_pid,
    output logic [ID_W-1:0] newest_pid,
    output logic [ID_W-1:0] newest_render_id
);

    logic    in_valid_reg;
    id_t     pid_reg;
    id_t     rtid_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_free;
    logic    advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    rlmb_list u_list
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_en    (advance),
        .pid       (pid_reg),
        .render_id (rtid_reg),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            pid_reg  <= pid;
            rtid_reg <= render_id;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = res_reg.status;
    assign evicted_pid      = res_reg.evicted_pid;
    assign newest_pid       = res_reg.newest_pid;
    assign newest_render_id = res_reg.newest_render_id;

endmodule

// File: verif/recency_list_move_to_back_top_tb.sv
// ----------------------------------------------------------------------------
// recency_list_move_to_back_top_tb
// Self-checking bench for the recency list with move-to-newest. A predictor
// mirrors the seven-slot list in the bench and works out status, evicted pid
// and newest pair for every input transfer. Each output transfer is then
// compared with the oldest prediction. A few directed touches cover the
// reset state and the extremes. Random touches drawn from small working sets
// follow, so that hits, moves and evictions all occur often. The sender
// idles in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module recency_list_move_to_back_top_tb;
    import rlmb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [ID_W-1:0] pid = '0;
    logic [ID_W-1:0] render_id = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [1:0]      status;
    logic [ID_W-1:0] evicted_pid;
    logic [ID_W-1:0] newest_pid;
    logic [ID_W-1:0] newest_render_id;

    // Bench copy of the list: index 0 is the oldest entry.
    id_t     list_pid [LIST_DEPTH];
    id_t     list_rtid[LIST_DEPTH];
    result_t expected_touch_results[$];

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int stall_kind = 0;
    int stall_phase_left = 0;

    recency_list_move_to_back_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pid              (pid),
        .render_id        (render_id),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .evicted_pid      (evicted_pid),
        .newest_pid       (newest_pid),
        .newest_render_id (newest_render_id)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("recency_list_move_to_back_top: mismatch");
            $finish;
        end
    end

    // Apply one touch to the bench list and return what the block must report.
    function automatic result_t touch_recency_list(id_t p, id_t r);
        result_t res;
        int      hit_at;
        id_t     moved_pid;
        id_t     moved_rtid;
        hit_at = -1;
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
            if (list_pid[i] == p)
                hit_at = i;
        res.evicted_pid = '0;
        if (hit_at == LIST_DEPTH - 1)
        begin
            res.status = ST_NEWEST;
        end
        else
        begin
            if (hit_at >= 0)
            begin
                res.status = ST_HIT;
                moved_pid  = list_pid[hit_at];
                moved_rtid = list_rtid[hit_at];
            end
            else
            begin
                res.status      = ST_MISS;
                res.evicted_pid = list_pid[0];
                moved_pid       = p;
                moved_rtid      = r;
                hit_at          = 0;
            end
            for (int i = hit_at; i < LIST_DEPTH - 1; i++)
            begin
                list_pid[i]  = list_pid[i + 1];
                list_rtid[i] = list_rtid[i + 1];
            end
            list_pid[LIST_DEPTH - 1]  = moved_pid;
            list_rtid[LIST_DEPTH - 1] = moved_rtid;
        end
        res.newest_pid       = list_pid[LIST_DEPTH - 1];
        res.newest_render_id = list_rtid[LIST_DEPTH - 1];
        return res;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_touch_results.size() == 0)
            begin
                $error("result transfer with no touch outstanding");
                errors++;
            end
            else
            begin
                want = expected_touch_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (evicted_pid !== want.evicted_pid)
                begin
                    $error("evicted_pid: expected %h, got %h", want.evicted_pid, evicted_pid);
                    errors++;
                end
                if (newest_pid !== want.newest_pid)
                begin
                    $error("newest_pid: expected %h, got %h", want.newest_pid, newest_pid);
                    errors++;
                end
                if (newest_render_id !== want.newest_render_id)
                begin
                    $error("newest_render_id: expected %h, got %h",
                           want.newest_render_id, newest_render_id);
                    errors++;
                end
            end
        end
    end

    // The receiver switches between free running, light, heavy and periodic stalls.
    always @(negedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_kind       = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(8, 80);
        end
        stall_phase_left--;
        case (stall_kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_phase_left % 5) < 2);
        endcase
    end

    task automatic send_touch(input id_t p, input id_t r);
        @(negedge clk);
        in_valid  <= 1'b1;
        pid       <= p;
        render_id <= r;
        do
            @(posedge clk);
        while (in_stall);
        expected_touch_results.push_back(touch_recency_list(p, r));
    endtask

    task automatic idle_input(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Sends one touch, then closes the burst, usually with an idle gap, when it runs out.
    task automatic push_touch(input id_t p, input id_t r);
        int gap;
        send_touch(p, r);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle_input(gap);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_touch_results.size() != 0)
            @(posedge clk);
    endtask

    // After reset every slot holds pid 0, so pid 0 hits the oldest slot and the
    // input render id must be ignored.
    task automatic test_duplicate_zero_pids();
        push_touch(22'h000000, 22'h3FFFFF);
        push_touch(22'h000000, 22'h2AAAAA);
        push_touch(22'h000000, 22'h155555);
    endtask

    task automatic test_directed_extremes();
        push_touch(22'h3FFFFF, 22'h3FFFFF);  // miss, evicts a zero
        push_touch(22'h3FFFFF, 22'h000000);  // already newest, render id kept
        push_touch(22'h155555, 22'h2AAAAA);
        push_touch(22'h2AAAAA, 22'h155555);
        push_touch(22'h000001, 22'h000002);
        push_touch(22'h200000, 22'h100000);
        drain_results();
        push_touch(22'h0ABCDE, 22'h3EDCBA);
        push_touch(22'h123456, 22'h000001);  // list now holds no zero entries
        push_touch(22'h155555, 22'h000000);  // hit on the second oldest keeps old render id
        push_touch(22'h3FFFFF, 22'h111111);  // hit on the oldest
        push_touch(22'h000000, 22'h3FFFFF);  // miss evicts a real entry
        push_touch(22'h000000, 22'h000000);
        push_touch(22'h3FFFFF, 22'h222222);
        push_touch(22'h2AAAAA, 22'h2AAAAA);
        push_touch(22'h000001, 22'h3FFFFF);
        push_touch(22'h000002, 22'h3FFFFF);
    endtask

    // Touches drawn mostly from a small working set, so that the list sees
    // many hits at every depth, with stray pids forcing evictions.
    task automatic test_working_set(input int count, input int set_size);
        id_t pool[16];
        id_t last_pid;
        id_t p;
        int  pick;
        for (int i = 0; i < 16; i++)
            pool[i] = id_t'($urandom());
        if ($urandom_range(0, 2) == 0)
            pool[0] = '0;
        last_pid = pool[0];
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                p = last_pid;
            else if (pick < 85)
                p = pool[$urandom_range(0, set_size - 1)];
            else
                p = id_t'($urandom());
            push_touch(p, id_t'($urandom()));
            last_pid = p;
        end
    endtask

    initial
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            list_pid[i]  = '0;
            list_rtid[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_duplicate_zero_pids();
        test_directed_extremes();
        drain_results();
        test_working_set(300, 6);
        test_working_set(300, 9);
        drain_results();
        test_working_set(250, 14);
        test_working_set(300, 4);

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("recency_list_move_to_back_top: match");
        else
            $display("recency_list_move_to_back_top: mismatch");
        $finish;
    end

endmodule

// File: recency_list_move_to_back_top.f
src/rlmb_pkg.sv
src/rlmb_match.sv
src/rlmb_list.sv
src/recency_list_move_to_back_top.sv
verif/recency_list_move_to_back_top_tb.sv
